// ----- sv/pmbgd_pkg.sv -----
package pmbgd_pkg;

  localparam int SampleW   = 16;
  localparam int StateW    = 32;
  localparam int CoeffW    = 15;
  localparam int DacW      = 8;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 15;

  localparam logic signed [SampleW-1:0] SampleMax = 16'sd32767;
  localparam logic signed [SampleW-1:0] SampleMin = -16'sd32768;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_STEREO    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_EIGHT_BIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BANDPASS  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HP_COEFF  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LP_COEFF  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GAIN      = 3'd5;

  localparam logic [CoeffW-1:0] HpCoeffReset = 15'd31000;
  localparam logic [CoeffW-1:0] LpCoeffReset = 15'd16384;
  localparam logic [CoeffW-1:0] GainReset    = 15'd1024;

  // One mono sample waiting between the front end and the filter engine.
  typedef struct packed {
    logic                      start;
    logic signed [SampleW-1:0] x;
  } pmbgd_item_t;

  // Settings the filter engine works with.
  typedef struct packed {
    logic              bandpass_on;
    logic [CoeffW-1:0] hp_coeff;
    logic [CoeffW-1:0] lp_coeff;
    logic [CoeffW-1:0] gain;
    logic              clear;
  } pmbgd_back_cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HP,
    S_LP,
    S_GAIN
  } pmbgd_state_t;

  // Saturates a 33-bit signed value to the 16-bit sample range.
  function automatic logic signed [SampleW-1:0] clamp16(input logic signed [32:0] v);
    logic signed [SampleW-1:0] r;
    if (v > 33'(SampleMax)) begin
      r = SampleMax;
    end else if (v < 33'(SampleMin)) begin
      r = SampleMin;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/pcm_mono_bandpass_gain_dac_unit.sv -----
// A sample goes from the queue into x_r, through the high-pass and low-pass steps (the
// low-pass step is skipped with the band-pass off) and the gain step into the output
// register, where a stalled result channel holds it. The back-end sequencer takes a new
// sample once the last has left the gain step; it runs the multiplies one after another.
// Reset (rst_n low, synchronous): queue and output emptied, filter state zeroed and all
// configuration registers set to their defaults.
module pcm_mono_bandpass_gain_dac_unit
  import pmbgd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input stream.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,   // first_channel[15:0], second_channel[31:16]
  input  logic                in_tuser,   // stream_start
  // Result stream.
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // dac_code[7:0], processed_sample[23:8]
  // Configuration write channel.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers. Writes are always accepted; an index past the
  // last register is ignored.
  logic              stereo_mode_r;
  logic              stereo_mode_nxt;
  logic              eight_bit_mode_r;
  logic              eight_bit_mode_nxt;
  logic              bandpass_on_r;
  logic              bandpass_on_nxt;
  logic [CoeffW-1:0] hp_coeff_r;
  logic [CoeffW-1:0] hp_coeff_nxt;
  logic [CoeffW-1:0] lp_coeff_r;
  logic [CoeffW-1:0] lp_coeff_nxt;
  logic [CoeffW-1:0] gain_r;
  logic [CoeffW-1:0] gain_nxt;
  logic              cfg_write;
  logic              filter_clear;

  pmbgd_item_t       front_item;
  pmbgd_item_t       q_item;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  pmbgd_back_cfg_t   back_cfg;
  logic [DacW-1:0]   dac_code;
  logic signed [SampleW-1:0] processed_sample;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Any write to the filter enable or a filter coefficient restarts the
  // filter from zero state, even if the value does not change.
  always_comb begin
    stereo_mode_nxt    = stereo_mode_r;
    eight_bit_mode_nxt = eight_bit_mode_r;
    bandpass_on_nxt    = bandpass_on_r;
    hp_coeff_nxt       = hp_coeff_r;
    lp_coeff_nxt       = lp_coeff_r;
    gain_nxt           = gain_r;
    filter_clear       = 1'b0;
    if (cfg_write) begin
      unique case (cfg_index)
        CFG_STEREO:    stereo_mode_nxt = cfg_data[0];
        CFG_EIGHT_BIT: eight_bit_mode_nxt = cfg_data[0];
        CFG_BANDPASS: begin
          bandpass_on_nxt = cfg_data[0];
          filter_clear    = 1'b1;
        end
        CFG_HP_COEFF: begin
          hp_coeff_nxt = cfg_data;
          filter_clear = 1'b1;
        end
        CFG_LP_COEFF: begin
          lp_coeff_nxt = cfg_data;
          filter_clear = 1'b1;
        end
        CFG_GAIN:      gain_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_mode_r    <= 1'b0;
      eight_bit_mode_r <= 1'b0;
      bandpass_on_r    <= 1'b1;
      hp_coeff_r       <= HpCoeffReset;
      lp_coeff_r       <= LpCoeffReset;
      gain_r           <= GainReset;
    end else begin
      stereo_mode_r    <= stereo_mode_nxt;
      eight_bit_mode_r <= eight_bit_mode_nxt;
      bandpass_on_r    <= bandpass_on_nxt;
      hp_coeff_r       <= hp_coeff_nxt;
      lp_coeff_r       <= lp_coeff_nxt;
      gain_r           <= gain_nxt;
    end
  end

  // The front end decodes and mixes each frame to one mono sample as the
  // transaction is accepted; the sample goes straight into the queue.
  pmbgd_front u_front (
    .stereo_mode    (stereo_mode_r),
    .eight_bit_mode (eight_bit_mode_r),
    .first_channel  (in_tdata[15:0]),
    .second_channel (in_tdata[31:16]),
    .stream_start   (in_tuser),
    .item           (front_item)
  );

  // A two-entry queue lets the front end keep taking frames while the
  // back end is busy with the multiplies or stalled by the result channel.
  assign in_tready = !q_full;

  pmbgd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  always_comb begin
    back_cfg.bandpass_on = bandpass_on_r;
    back_cfg.hp_coeff    = hp_coeff_r;
    back_cfg.lp_coeff    = lp_coeff_r;
    back_cfg.gain        = gain_r;
    back_cfg.clear       = filter_clear;
  end

  // The back end owns the filter state and runs one multiply per cycle unless stalled:
  // high-pass, low-pass (skipped with band-pass off), then gain into the output register.
  pmbgd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (back_cfg),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .dac_code         (dac_code),
    .processed_sample (processed_sample)
  );

  assign out_tdata = {processed_sample, dac_code};

endmodule

// ----- sv/pmbgd_front.sv -----
module pmbgd_front
  import pmbgd_pkg::*;
(
  input  logic               stereo_mode,
  input  logic               eight_bit_mode,
  input  logic [SampleW-1:0] first_channel,
  input  logic [SampleW-1:0] second_channel,
  input  logic               stream_start,
  output pmbgd_item_t        item
);

  logic signed [SampleW:0]   ch0;
  logic signed [SampleW:0]   ch1;
  logic signed [SampleW+1:0] sum;
  logic signed [SampleW+1:0] half;
  logic signed [SampleW+1:0] mono;

  // An 8-bit channel is an offset-binary byte scaled up to full range.
  always_comb begin
    if (eight_bit_mode) begin
      ch0 = $signed({1'b0, ~first_channel[7], first_channel[6:0], 8'd0});
      ch1 = $signed({1'b0, ~second_channel[7], second_channel[6:0], 8'd0});
      ch0[SampleW] = ~first_channel[7];
      ch1[SampleW] = ~second_channel[7];
    end else begin
      ch0 = 17'($signed(first_channel));
      ch1 = 17'($signed(second_channel));
    end
  end

  // Stereo average truncates toward zero: add one to a negative sum first.
  always_comb begin
    sum  = 18'(ch0) + 18'(ch1);
    half = (sum + (sum[SampleW+1] ? 18'sd1 : 18'sd0)) >>> 1;
    mono = stereo_mode ? half : 18'(ch0);
    item.x     = clamp16(33'(mono));
    item.start = stream_start;
  end

endmodule

// ----- sv/pmbgd_queue.sv -----
module pmbgd_queue
  import pmbgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  pmbgd_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        pop_valid,
  output pmbgd_item_t pop_item
);

  pmbgd_item_t slot_r [2];
  logic        wr_ptr_r;
  logic        wr_ptr_nxt;
  logic        rd_ptr_r;
  logic        rd_ptr_nxt;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  logic        do_push;
  logic        do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- sv/pmbgd_back.sv -----
module pmbgd_back
  import pmbgd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  pmbgd_back_cfg_t           cfg,
  input  logic                      q_valid,
  input  pmbgd_item_t               q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DacW-1:0]           dac_code,
  output logic signed [SampleW-1:0] processed_sample
);

  pmbgd_state_t              state_r;
  pmbgd_state_t              state_nxt;
  logic signed [SampleW-1:0] x_r;
  logic signed [SampleW-1:0] x_nxt;
  logic signed [SampleW-1:0] hpi_r;
  logic signed [SampleW-1:0] hpi_nxt;
  logic signed [StateW-1:0]  hpo_r;
  logic signed [StateW-1:0]  hpo_nxt;
  logic signed [StateW-1:0]  lpo_r;
  logic signed [StateW-1:0]  lpo_nxt;
  logic signed [SampleW-1:0] s_r;
  logic signed [SampleW-1:0] s_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [DacW-1:0]           dac_r;
  logic [DacW-1:0]           dac_nxt;
  logic signed [SampleW-1:0] smp_r;
  logic signed [SampleW-1:0] smp_nxt;

  logic signed [StateW+1:0]  hp_diff;
  logic signed [StateW+17:0] hp_prod;
  logic signed [StateW:0]    lp_diff;
  logic signed [StateW+16:0] lp_prod;
  logic signed [StateW-1:0]  lp_new;
  logic signed [2*SampleW-1:0] gain_prod;
  logic signed [SampleW-1:0] gained;
  logic                      out_free;

  assign out_valid        = out_valid_r;
  assign dac_code         = dac_r;
  assign processed_sample = smp_r;
  assign out_free         = !out_valid_r || out_ready;

  always_comb begin
    hp_diff   = 34'(hpo_r) + 34'(x_r) - 34'(hpi_r);
    hp_prod   = hp_diff * $signed({1'b0, cfg.hp_coeff});
    lp_diff   = 33'(hpo_r) - 33'(lpo_r);
    lp_prod   = lp_diff * $signed({1'b0, cfg.lp_coeff});
    lp_new    = lpo_r + lp_prod[46:15];
    gain_prod = s_r * $signed({1'b0, cfg.gain});
    gained    = clamp16(33'($signed(gain_prod[2*SampleW-1:15])));
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    hpi_nxt       = hpi_r;
    hpo_nxt       = hpo_r;
    lpo_nxt       = lpo_r;
    s_nxt         = s_r;
    dac_nxt       = dac_r;
    smp_nxt       = smp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          x_nxt     = q_item.x;
          state_nxt = S_HP;
          if (q_item.start) begin
            hpi_nxt = '0;
            hpo_nxt = '0;
            lpo_nxt = '0;
          end
        end
      end
      S_HP: begin
        if (cfg.bandpass_on) begin
          hpi_nxt   = x_r;
          hpo_nxt   = hp_prod[46:15];
          state_nxt = S_LP;
        end else begin
          s_nxt     = x_r;
          state_nxt = S_GAIN;
        end
      end
      S_LP: begin
        lpo_nxt   = lp_new;
        s_nxt     = clamp16(33'(lp_new));
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        if (out_free) begin
          smp_nxt       = gained;
          dac_nxt       = {~gained[SampleW-1], gained[SampleW-2:SampleW-DacW]};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg.clear) begin
      hpi_nxt = '0;
      hpo_nxt = '0;
      lpo_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hpi_r       <= '0;
      hpo_r       <= '0;
      lpo_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hpi_r       <= hpi_nxt;
      hpo_r       <= hpo_nxt;
      lpo_r       <= lpo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    s_r   <= s_nxt;
    dac_r <= dac_nxt;
    smp_r <= smp_nxt;
  end

`ifndef NO_ASSERTIONS
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_HP)
    else $error("popped item did not start the high-pass step");

  a_lp_to_gain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LP |=> state_r == S_GAIN)
    else $error("low-pass step not followed by gain step");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.clear |=> hpo_r == 0 && lpo_r == 0 && hpi_r == 0)
    else $error("filter state not cleared by configuration write");

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HP && !cfg.bandpass_on |=> state_r == S_GAIN && s_r == $past(x_r))
    else $error("bypass did not pass the mono sample through");

  a_gain_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GAIN && out_valid_r && !out_ready |=> state_r == S_GAIN)
    else $error("result dropped while output register was full");
`endif

endmodule
